// File: rtl/wia128_pkg.sv
// ----------------------------------------------------------------------------
// wia128_pkg - shared types and constants of the 128-bit serial integer ALU
// Operation codes, compare codes, sequencer states and the datapath control
// group that passes from the sequencer to the bit-serial datapath.
// ----------------------------------------------------------------------------
package wia128_pkg;

    localparam int WORD_W  = 128;
    localparam int HALF_W  = 64;
    localparam int SHAMT_W = 9;
    localparam int STEP_W  = 7;                    // indexes the 128 bit steps
    localparam int LZ_W    = 8;
    localparam int ORD_W   = 2;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(WORD_W - 1);
    localparam logic [LZ_W-1:0]   LZ_ALL    = LZ_W'(WORD_W);

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,   // add, writes carry
        OP_ADDK = 3'd1,   // add, carry kept
        OP_SUB  = 3'd2,   // subtract, writes borrow
        OP_SUBK = 3'd3,   // subtract, borrow kept
        OP_MUL  = 3'd4,
        OP_DIV  = 3'd5,
        OP_SHR  = 3'd6,
        OP_SHL  = 3'd7
    } op_t;

    localparam logic [ORD_W-1:0] ORD_EQ = 2'b00;
    localparam logic [ORD_W-1:0] ORD_GT = 2'b01;
    localparam logic [ORD_W-1:0] ORD_LT = 2'b11;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;   // capture a new request
        logic step;   // advance the serial datapath by one bit
        logic last;   // this step is the final one
    } ctrl_t;

endpackage

// File: rtl/wide_integer_alu_128.sv
// ----------------------------------------------------------------------------
// wide_integer_alu_128 - 128-bit unsigned integer ALU, bit-serial
// Add/subtract, 64x64 multiply, 128/64 divide and logical shifts, each
// result tagged with compare, leading-zero count, zero flag, carry and
// divide-by-zero.
// ----------------------------------------------------------------------------
// Every request holds the unit until its result is moved out. The accepting
// cycle captures the operands. Then come 128 bit steps of the serial
// datapath: the restoring divide needs one step per dividend bit, and all
// operations run the same count. The done state then moves the result into
// the output register, which raises m_tvalid, and the unit returns to idle,
// where the next request can be accepted. s_tready is high only
// while no request is in progress. The output register holds a finished
// result until it is taken, so the next request can be accepted while that
// result still waits. A result that finishes while the previous one is still
// waiting stalls the unit until the output register frees up. Operation codes
// travel in s_tuser: 0 add (updates carry), 1 add (carry kept), 2 subtract
// (updates borrow), 3 subtract (borrow kept), 4 a_low * b_low, 5 A / b_low,
// 6 shift right, 7 shift left. Shifts use the absolute value of the signed
// count; 128 or more gives zero. A divide by zero returns zeros with
// divide_by_zero set. The carry flag is the only state kept between requests
// and resets to zero.
// ----------------------------------------------------------------------------
module wide_integer_alu_128
    import wia128_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // a_low[63:0], a_high[127:64], b_low[191:128], b_high[255:192],
    // shift_amount[264:256], zero fill
    input  logic [271:0] s_tdata,
    // kind[2:0]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // result_low[63:0], result_high[127:64], remainder[191:128],
    // order[193:192], leading_zeros[201:194], is_zero[202], carry[203],
    // divide_by_zero[204], zero fill
    output logic [207:0] m_tdata
);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg,   cnt_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [207:0]      m_tdata_reg,  m_tdata_next;

    ctrl_t             ctrl;
    logic              out_free;
    logic              out_load;

    logic [HALF_W-1:0] dp_result_low;
    logic [HALF_W-1:0] dp_result_high;
    logic [HALF_W-1:0] dp_remainder;
    logic [ORD_W-1:0]  dp_order;
    logic [LZ_W-1:0]   dp_leading_zeros;
    logic              dp_is_zero;
    logic              dp_carry;
    logic              dp_divide_by_zero;

    assign out_free = !m_tvalid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_RUN;
            end
            ST_RUN: begin
                if (cnt_reg == LAST_STEP) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready  = 1'b0;
        ctrl      = '0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                ctrl.load = s_tvalid;
            end
            ST_RUN: begin
                ctrl.step = 1'b1;
                ctrl.last = (cnt_reg == LAST_STEP);
            end
            ST_DONE: begin
                out_load = out_free;
            end
            default: ;
        endcase
    end

    // step counter: cleared on capture, wraps after the last step
    always_comb begin
        cnt_next = cnt_reg;
        if (ctrl.load) begin
            cnt_next = '0;
        end else if (ctrl.step) begin
            cnt_next = cnt_reg + STEP_W'(1);
        end
    end

    // output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {3'b000, dp_divide_by_zero, dp_carry, dp_is_zero,
                             dp_leading_zeros, dp_order, dp_remainder,
                             dp_result_high, dp_result_low};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        cnt_reg     <= cnt_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    wia128_serial u_serial (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl),
        .step_idx       (cnt_reg),
        .op             (op_t'(s_tuser)),
        .a_low          (s_tdata[63:0]),
        .a_high         (s_tdata[127:64]),
        .b_low          (s_tdata[191:128]),
        .b_high         (s_tdata[255:192]),
        .shift_amount   ($signed(s_tdata[264:256])),
        .result_low     (dp_result_low),
        .result_high    (dp_result_high),
        .remainder      (dp_remainder),
        .order          (dp_order),
        .leading_zeros  (dp_leading_zeros),
        .is_zero        (dp_is_zero),
        .carry          (dp_carry),
        .divide_by_zero (dp_divide_by_zero)
    );

endmodule

// File: rtl/wia128_serial.sv
// ----------------------------------------------------------------------------
// wia128_serial - bit-serial datapath of the 128-bit integer ALU
// One bit of every operation per step: ripple add/subtract, shift-add
// multiply, restoring divide, one-place shifts, plus compare and
// leading-zero tracking on the operand bits as they stream past.
// ----------------------------------------------------------------------------
module wia128_serial
    import wia128_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  ctrl_t                     ctrl,
    input  logic [STEP_W-1:0]         step_idx,
    input  op_t                       op,
    input  logic [HALF_W-1:0]         a_low,
    input  logic [HALF_W-1:0]         a_high,
    input  logic [HALF_W-1:0]         b_low,
    input  logic [HALF_W-1:0]         b_high,
    input  logic signed [SHAMT_W-1:0] shift_amount,
    output logic [HALF_W-1:0]         result_low,
    output logic [HALF_W-1:0]         result_high,
    output logic [HALF_W-1:0]         remainder,
    output logic [ORD_W-1:0]          order,
    output logic [LZ_W-1:0]           leading_zeros,
    output logic                      is_zero,
    output logic                      carry,
    output logic                      divide_by_zero
);

    op_t                op_reg,    op_next;
    logic [WORD_W-1:0]  a_sh_reg,  a_sh_next;
    logic [WORD_W-1:0]  b_sh_reg,  b_sh_next;
    logic [WORD_W-1:0]  res_reg,   res_next;
    logic [HALF_W-1:0]  opnd_reg,  opnd_next;   // multiplicand or divisor
    logic [HALF_W-1:0]  rem_reg,   rem_next;
    logic [SHAMT_W-1:0] amt_reg,   amt_next;
    logic               dz_reg,    dz_next;
    logic [ORD_W-1:0]   ord_reg,   ord_next;
    logic [STEP_W-1:0]  lz_reg,    lz_next;
    logic               nz_reg,    nz_next;     // a one bit of A was seen
    logic               sc_reg,    sc_next;     // serial carry / borrow
    logic               carry_reg, carry_next;  // architectural flag

    logic               abit, bbit;
    logic               add_bit, add_cout, sub_bit, sub_bout;
    logic [HALF_W:0]    mul_sum;
    logic [HALF_W-1:0]  div_sh;
    logic [HALF_W:0]    div_diff;
    logic               div_ge;
    logic               shift_en;
    logic [SHAMT_W-1:0] sa_u;

    assign abit     = a_sh_reg[0];
    assign bbit     = b_sh_reg[0];
    assign add_bit  = abit ^ bbit ^ sc_reg;
    assign add_cout = (abit & bbit) | (sc_reg & (abit ^ bbit));
    assign sub_bit  = abit ^ bbit ^ sc_reg;
    assign sub_bout = (~abit & bbit) | (~(abit ^ bbit) & sc_reg);

    // shift-add: multiplicand joins the upper half, product slides right
    assign mul_sum  = {1'b0, res_reg[WORD_W-1:HALF_W]}
                    + (bbit ? {1'b0, opnd_reg} : {(HALF_W+1){1'b0}});

    // restoring step: dividend bits leave the top of res, quotient bits enter
    assign div_sh   = {rem_reg[HALF_W-2:0], res_reg[WORD_W-1]};
    assign div_diff = {rem_reg[HALF_W-1], div_sh} - {1'b0, opnd_reg};
    assign div_ge   = ~div_diff[HALF_W];

    assign shift_en = {2'b00, step_idx} < amt_reg;
    assign sa_u     = $unsigned(shift_amount);

    always_comb begin
        op_next    = op_reg;
        a_sh_next  = a_sh_reg;
        b_sh_next  = b_sh_reg;
        res_next   = res_reg;
        opnd_next  = opnd_reg;
        rem_next   = rem_reg;
        amt_next   = amt_reg;
        dz_next    = dz_reg;
        ord_next   = ord_reg;
        lz_next    = lz_reg;
        nz_next    = nz_reg;
        sc_next    = sc_reg;
        carry_next = carry_reg;

        if (ctrl.load) begin
            op_next   = op;
            a_sh_next = {a_high, a_low};
            b_sh_next = {b_high, b_low};
            res_next  = (op == OP_MUL) ? '0 : {a_high, a_low};
            opnd_next = (op == OP_MUL) ? a_low : b_low;
            rem_next  = '0;
            // -256 wraps to itself and reads as 256
            amt_next  = sa_u[SHAMT_W-1] ? (SHAMT_W'(0) - sa_u) : sa_u;
            dz_next   = (op == OP_DIV) && (b_low == '0);
            ord_next  = ORD_EQ;
            lz_next   = '0;
            nz_next   = 1'b0;
            sc_next   = 1'b0;
        end else if (ctrl.step) begin
            a_sh_next = {1'b0, a_sh_reg[WORD_W-1:1]};
            b_sh_next = {1'b0, b_sh_reg[WORD_W-1:1]};
            // LSB first, so the most significant difference lands last
            if (abit != bbit) begin
                ord_next = abit ? ORD_GT : ORD_LT;
            end
            if (abit) begin
                lz_next = ~step_idx;
                nz_next = 1'b1;
            end
            case (op_reg)
                OP_ADD, OP_ADDK: begin
                    res_next = {add_bit, res_reg[WORD_W-1:1]};
                    sc_next  = add_cout;
                end
                OP_SUB, OP_SUBK: begin
                    res_next = {sub_bit, res_reg[WORD_W-1:1]};
                    sc_next  = sub_bout;
                end
                OP_MUL: begin
                    if (!step_idx[STEP_W-1]) begin
                        res_next = {mul_sum, res_reg[HALF_W-1:1]};
                    end
                end
                OP_DIV: begin
                    rem_next = div_ge ? div_diff[HALF_W-1:0] : div_sh;
                    res_next = {res_reg[WORD_W-2:0], div_ge};
                end
                OP_SHR: begin
                    if (shift_en) begin
                        res_next = {1'b0, res_reg[WORD_W-1:1]};
                    end
                end
                default: begin
                    if (shift_en) begin
                        res_next = {res_reg[WORD_W-2:0], 1'b0};
                    end
                end
            endcase
            if (ctrl.last && (op_reg == OP_ADD || op_reg == OP_SUB)) begin
                carry_next = sc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carry_reg <= 1'b0;
        end else begin
            carry_reg <= carry_next;
        end
        op_reg   <= op_next;
        a_sh_reg <= a_sh_next;
        b_sh_reg <= b_sh_next;
        res_reg  <= res_next;
        opnd_reg <= opnd_next;
        rem_reg  <= rem_next;
        amt_reg  <= amt_next;
        dz_reg   <= dz_next;
        ord_reg  <= ord_next;
        lz_reg   <= lz_next;
        nz_reg   <= nz_next;
        sc_reg   <= sc_next;
    end

    assign result_low     = dz_reg ? '0 : res_reg[HALF_W-1:0];
    assign result_high    = dz_reg ? '0 : res_reg[WORD_W-1:HALF_W];
    assign remainder      = dz_reg ? '0 : rem_reg;
    assign order          = ord_reg;
    assign leading_zeros  = nz_reg ? {1'b0, lz_reg} : LZ_ALL;
    assign is_zero        = ~nz_reg;
    assign carry          = carry_reg;
    assign divide_by_zero = dz_reg;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the 128-bit serial integer ALU
// Sends corner-case and random requests into the stream input, predicts each
// result with an in-bench model of the ALU and its carry flag, and checks
// every returned result field by field; both sides stall at random except in the tail.
// ----------------------------------------------------------------------------
module tb_top;
    import wia128_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 8;
    localparam int RANDOM_REQUESTS = 1050;
    localparam int DRAIN_CYCLES    = 140;        // idle time after the last result is checked
    localparam int CYCLE_LIMIT     = 1_000_000;  // watchdog limit on the whole run
    localparam int MAX_IDLE        = 19;

    // one result as it sits in m_tdata, MSB field first
    typedef struct packed {
        logic              divide_by_zero;
        logic              carry;
        logic              is_zero;
        logic [LZ_W-1:0]   leading_zeros;
        logic [ORD_W-1:0]  order;
        logic [HALF_W-1:0] remainder;
        logic [HALF_W-1:0] result_high;
        logic [HALF_W-1:0] result_low;
    } alu_result_t;

    // ------------------------------------------------------------------
    // scoreboard: predicts results in request order, checks them in order
    // ------------------------------------------------------------------
    class alu_scoreboard;
        logic        carry_flag;
        alu_result_t pending_results[$];
        int          errors;

        function new();
            carry_flag = 1'b0;
            errors     = 0;
        endfunction

        // in-bench model of one request; updates the carry flag as the ALU does
        function alu_result_t compute_alu_result(op_t op, logic [WORD_W-1:0] a,
                                                 logic [WORD_W-1:0] b,
                                                 logic [SHAMT_W-1:0] sh);
            alu_result_t       r;
            logic [WORD_W:0]   sum;
            logic [WORD_W-1:0] value;
            logic [WORD_W-1:0] divisor;
            int                amt;
            r       = '0;
            value   = '0;
            divisor = {{HALF_W{1'b0}}, b[HALF_W-1:0]};
            // absolute count; the most negative code gives 256
            amt = int'($signed(sh));
            if (amt < 0) begin
                amt = -amt;
            end
            case (op)
                OP_ADD, OP_ADDK: begin
                    sum   = {1'b0, a} + {1'b0, b};
                    value = sum[WORD_W-1:0];
                    if (op == OP_ADD) begin
                        carry_flag = sum[WORD_W];
                    end
                end
                OP_SUB, OP_SUBK: begin
                    value = a - b;
                    if (op == OP_SUB) begin
                        carry_flag = (a < b);
                    end
                end
                OP_MUL: begin
                    value = {{HALF_W{1'b0}}, a[HALF_W-1:0]} * divisor;
                end
                OP_DIV: begin
                    if (b[HALF_W-1:0] == '0) begin
                        r.divide_by_zero = 1'b1;
                    end else begin
                        value       = a / divisor;
                        r.remainder = HALF_W'(a % divisor);
                    end
                end
                OP_SHR: begin
                    value = (amt >= WORD_W) ? '0 : a >> amt;
                end
                default: begin
                    value = (amt >= WORD_W) ? '0 : a << amt;
                end
            endcase
            r.result_low  = value[HALF_W-1:0];
            r.result_high = value[WORD_W-1:HALF_W];
            r.order       = (a > b) ? ORD_GT : (a < b) ? ORD_LT : ORD_EQ;
            r.leading_zeros = LZ_ALL;
            for (int i = 0; i < WORD_W; i++) begin
                if (a[i]) begin
                    r.leading_zeros = LZ_W'(WORD_W - 1 - i);
                end
            end
            r.is_zero = (a == '0);
            r.carry   = carry_flag;
            return r;
        endfunction

        function void note_request(op_t op, logic [WORD_W-1:0] a, logic [WORD_W-1:0] b,
                                   logic [SHAMT_W-1:0] sh);
            pending_results.push_back(compute_alu_result(op, a, b, sh));
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        task report(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
            errors++;
            $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
        endtask

        task check_result(logic [207:0] data);
            alu_result_t got;
            alu_result_t want;
            got = data[$bits(alu_result_t)-1:0];
            if (pending_results.size() == 0) begin
                report("result with no request pending", data[WORD_W-1:0], '0);
                return;
            end
            want = pending_results.pop_front();
            if (got.result_low !== want.result_low)
                report("result_low", WORD_W'(got.result_low), WORD_W'(want.result_low));
            if (got.result_high !== want.result_high)
                report("result_high", WORD_W'(got.result_high),
                       WORD_W'(want.result_high));
            if (got.remainder !== want.remainder)
                report("remainder", WORD_W'(got.remainder), WORD_W'(want.remainder));
            if (got.order !== want.order)
                report("order", WORD_W'(got.order), WORD_W'(want.order));
            if (got.leading_zeros !== want.leading_zeros)
                report("leading_zeros", WORD_W'(got.leading_zeros),
                       WORD_W'(want.leading_zeros));
            if (got.is_zero !== want.is_zero)
                report("is_zero", WORD_W'(got.is_zero), WORD_W'(want.is_zero));
            if (got.carry !== want.carry)
                report("carry", WORD_W'(got.carry), WORD_W'(want.carry));
            if (got.divide_by_zero !== want.divide_by_zero)
                report("divide_by_zero", WORD_W'(got.divide_by_zero),
                       WORD_W'(want.divide_by_zero));
        endtask
    endclass

    // ------------------------------------------------------------------
    // clock, reset, DUT
    // ------------------------------------------------------------------
    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [271:0] s_tdata  = '0;   // a_low, a_high, b_low, b_high, shift_amount, fill
    logic [2:0]   s_tuser  = OP_ADD; // kind
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [207:0] m_tdata;         // result_low, result_high, remainder, order,
                                   // leading_zeros, is_zero, carry, divide_by_zero

    int            idle_pct    = 0;  // stall pressure for both sides, 0 = none
    int            cycle_count = 0;
    alu_scoreboard sb;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    wide_integer_alu_128 u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // handshake monitor: values read here are the ones sampled at this edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_request(op_t'(s_tuser), s_tdata[WORD_W-1:0],
                                s_tdata[2*WORD_W-1:WORD_W],
                                s_tdata[2*WORD_W+SHAMT_W-1:2*WORD_W]);
            end
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
            end
        end
    end

    // ------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------
    // valid stays high from one request to the next unless a gap is drawn
    task automatic send_request(input op_t op, input logic [WORD_W-1:0] a,
                                input logic [WORD_W-1:0] b,
                                input logic [SHAMT_W-1:0] sh);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, MAX_IDLE)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, sh, b, a};
        do @(posedge aclk); while (!s_tready);
    endtask

    // mostly random words, with enough zeros, ones and single bits to hit
    // carry chains, divide by zero and leading-zero corners
    function automatic logic [HALF_W-1:0] random_half();
        int unsigned k;
        k = $urandom_range(0, HALF_W - 1);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return HALF_W'($urandom_range(0, 15));
            3: return HALF_W'(1) << k;
            4: return ~(HALF_W'(1) << k);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // shift counts: full 9-bit range, biased toward the word boundaries
    function automatic logic [SHAMT_W-1:0] random_shift();
        int boundary_counts[10] = '{0, 1, 63, 64, 65, 127, 128, 129, 255, 256};
        int c;
        if ($urandom_range(0, 3) != 0) begin
            return SHAMT_W'($urandom);
        end
        c = boundary_counts[$urandom_range(0, 9)];
        return ($urandom_range(0, 1) != 0) ? SHAMT_W'(-c) : SHAMT_W'(c);
    endfunction

    task automatic run_directed();
        send_request(OP_ADD,  '1, 128'd1, '0);              // carry out of bit 127
        send_request(OP_ADDK, '0, '0, '0);                  // A zero, carry kept set
        send_request(OP_ADD,  '0, '0, '0);                  // carry cleared
        send_request(OP_SUB,  '0, 128'd1, '0);              // borrow, A < B
        send_request(OP_SUBK, '1, '1, '0);                  // equal, borrow kept
        send_request(OP_SUB,  '1, '0, '0);                  // no borrow, A > B
        send_request(OP_ADD,  {64'd0, {HALF_W{1'b1}}}, 128'd1, '0); // low-half carry
        send_request(OP_MUL,  '1, '1, '0);                  // largest product
        send_request(OP_MUL,  {{HALF_W{1'b1}}, 64'd0}, '1, '0);
        send_request(OP_DIV,  '1, 128'd1, '0);
        send_request(OP_DIV,  '1, {64'd0, {HALF_W{1'b1}}}, '0);
        send_request(OP_DIV,  '1, {{HALF_W{1'b1}}, 64'd0}, '0); // divide by zero
        send_request(OP_DIV,  '0, 128'd7, '0);
        send_request(OP_SHR,  '1, '0, '0);                  // shift by zero
        send_request(OP_SHR,  {1'b1, 127'd0}, '0, SHAMT_W'(127));
        send_request(OP_SHR,  '1, '0, SHAMT_W'(-64));
        send_request(OP_SHR,  '1, '0, SHAMT_W'(128));       // large shift
        send_request(OP_SHR,  '1, '0, SHAMT_W'(-256));      // most negative count
        send_request(OP_SHL,  '1, '0, SHAMT_W'(255));
        send_request(OP_SHL,  '1, '0, SHAMT_W'(-1));
        send_request(OP_SHL,  '1, '0, SHAMT_W'(64));
        send_request(OP_SHL,  128'd1, '0, SHAMT_W'(-127));
        send_request(OP_ADDK, {64'd3, 64'd5}, {64'd3, 64'd9}, '0); // order from low half
        send_request(OP_SUBK, 128'd1, '0, '0);              // 127 leading zeros
    endtask

    // ------------------------------------------------------------------
    // result side: random back-pressure bursts
    // ------------------------------------------------------------------
    initial begin
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (idle_pct != 0 && $urandom_range(0, 399) < idle_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, MAX_IDLE)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        sb       = new();
        idle_pct = 10;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        run_directed();

        // random requests; pressure rises, then eases off, and the tail runs flat out
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            idle_pct = (n < 300) ? 10 : (n < 600) ? 40 : (n < 900) ? 3 : 0;
            a = {random_half(), random_half()};
            case ($urandom_range(0, 7))
                0: b = a;
                1: b = {a[WORD_W-1:HALF_W], random_half()};
                default: b = {random_half(), random_half()};
            endcase
            send_request(op_t'($urandom_range(0, 7)), a, b, random_shift());
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
